// File: sv/mnps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mnps_pkg: shared types and constants for the Manhattan nearest point search
// Holds the request record that travels down the cell chain and its widths.
// ---------------------------------------------------------------------------
package mnps_pkg;

  // default number of cells, one stored point per cell
  localparam int MNPS_CAPACITY = 1024;

  localparam int COORD_W = 20;
  localparam int DIST_W  = COORD_W + 1;

  // running minimum starts above any real distance
  localparam logic [DIST_W-1:0] DIST_INIT = {DIST_W{1'b1}};

  // request kinds carried in the mode bit
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // one request moving through the chain
  typedef struct packed {
    logic               vld;   // slot holds a live request
    logic               mode;  // MODE_INSERT or MODE_QUERY
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               hit;   // query has met at least one stored point
    logic [DIST_W-1:0]  best;  // running minimum distance
  } mnps_item_t;

endpackage

// File: sv/mnps_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mnps_cell: one stage of the point chain
// Holds at most one point. An insert is captured by the first empty cell it
// meets; a query folds this cell's distance into its running minimum.
// ---------------------------------------------------------------------------
module mnps_cell
  import mnps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,      // whole chain moves one step
  input  mnps_item_t item_i,
  output mnps_item_t item_o,
  output logic       occ_o     // cell holds a point
);

  logic               occ_r, occ_nxt;
  logic [COORD_W-1:0] px_r, px_nxt;
  logic [COORD_W-1:0] py_r, py_nxt;
  logic               vld_r, vld_nxt;
  mnps_item_t         item_r, item_nxt;

  logic [COORD_W-1:0] dx, dy;
  logic [DIST_W-1:0]  man_dist;
  logic               take;

  // distance from the stored point to the request point
  always_comb begin
    dx       = (px_r > item_i.x) ? (px_r - item_i.x) : (item_i.x - px_r);
    dy       = (py_r > item_i.y) ? (py_r - item_i.y) : (item_i.y - py_r);
    man_dist = {1'b0, dx} + {1'b0, dy};
  end

  // capture inserts into an empty cell, update queries against a full one
  always_comb begin
    take     = item_i.vld && (item_i.mode == MODE_INSERT) && !occ_r;
    occ_nxt  = occ_r || take;
    px_nxt   = take ? item_i.x : px_r;
    py_nxt   = take ? item_i.y : py_r;
    item_nxt = item_i;
    vld_nxt  = item_i.vld && !take;
    if (item_i.vld && (item_i.mode == MODE_QUERY) && occ_r) begin
      item_nxt.hit = 1'b1;
      if (man_dist < item_i.best) begin
        item_nxt.best = man_dist;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      vld_r <= 1'b0;
    end else if (adv) begin
      occ_r <= occ_nxt;
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      item_r <= item_nxt;
    end
  end

  always_comb begin
    item_o     = item_r;
    item_o.vld = vld_r;
  end

  assign occ_o = occ_r;

endmodule

// File: sv/manhattan_nearest_point_search_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// manhattan_nearest_point_search_top: nearest stored point, Manhattan metric
// Keeps up to CAPACITY 2-D points in a chain of cells and answers queries
// with the smallest |dx|+|dy| over all stored points.
// ---------------------------------------------------------------------------
// Requests enter a chain of CAPACITY cells, one point per cell, and move one
// cell per cycle, so a new request is taken every cycle. An insert (tuser 0)
// lands in the first empty cell and gives no result; once all cells are full
// further inserts fall off the end of the chain. A query (tuser 1) collects
// the minimum over every cell and leaves the chain as one result, through
// the output register, in request order. If no point is stored the
// result has tuser set and a distance of zero. The chain has no skid buffer:
// while a result waits in the output register the whole chain holds, and
// in_tready drops with it. No startup sweep is needed after reset.
// ---------------------------------------------------------------------------
module manhattan_nearest_point_search_top
  import mnps_pkg::*;
#(
  parameter int CAPACITY = MNPS_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // x_coord[19:0], y_coord[39:20]
  input  logic [0:0]  in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // distance[20:0], zero pad[23:21]
  output logic [0:0]  out_tuser   // store_empty[0]
);

  mnps_item_t          chain [CAPACITY+1];
  logic [CAPACITY-1:0] occ_vec;
  logic                adv;

  logic              out_vld_r, out_vld_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_empty_r, out_empty_nxt;

  // chain steps whenever the output register can take what arrives
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;

  // request entering the first cell
  always_comb begin
    chain[0].vld  = in_tvalid;
    chain[0].mode = in_tuser[0];
    chain[0].x    = in_tdata[COORD_W-1:0];
    chain[0].y    = in_tdata[2*COORD_W-1:COORD_W];
    chain[0].hit  = 1'b0;
    chain[0].best = DIST_INIT;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mnps_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .item_i (chain[i]),
      .item_o (chain[i+1]),
      .occ_o  (occ_vec[i])
    );
  end

  // result register: only queries leave the chain
  always_comb begin
    out_vld_nxt   = chain[CAPACITY].vld && (chain[CAPACITY].mode == MODE_QUERY);
    out_empty_nxt = !chain[CAPACITY].hit;
    out_dist_nxt  = chain[CAPACITY].hit ? chain[CAPACITY].best : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dist_r  <= out_dist_nxt;
      out_empty_r <= out_empty_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(24-DIST_W){1'b0}}, out_dist_r};
  assign out_tuser  = out_empty_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // cells fill strictly from the front of the chain
  a_fill_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((occ_vec + CAPACITY'(1)) & occ_vec) == '0)
    else $error("occupied cells are not a prefix of the chain");

  // an empty-store result always reports distance zero
  a_empty_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("empty-store result carries a nonzero distance");

  // a real distance needs at least one stored point
  a_hit_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> occ_vec[0])
    else $error("result found a point while the store is empty");

  // a point stored in the first cell is never lost
  a_occ_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    occ_vec[0] |=> occ_vec[0])
    else $error("first cell lost its point");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the Manhattan nearest point search
// A directed table, then random insert and query requests with bursty
// backpressure on both streams. Each query result is checked against its
// typed value or a brute-force minimum over a local copy of the point store.
// ---------------------------------------------------------------------------
module tb_top;
  import mnps_pkg::*;

  // chain at its default length
  localparam int CAP          = MNPS_CAPACITY;
  localparam int RANDOM_COUNT = 950;
  localparam int QUIET_TAIL   = 100;
  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              empty;
  } nearest_result_t;

  typedef struct packed {
    logic               mode;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               typed;  // expected value written in the row
    logic [DIST_W-1:0]  distance;
    logic               empty;
  } stim_row_t;

  localparam int DIRECTED_COUNT = 20;

  // typed rows: empty store, corners, center, exact hits
  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    '{MODE_QUERY,  20'h00000, 20'h00000, 1'b1, 21'd0,       1'b1},
    '{MODE_QUERY,  20'hFFFFF, 20'hFFFFF, 1'b1, 21'd0,       1'b1},
    '{MODE_INSERT, 20'h00000, 20'h00000, 1'b0, 21'd0,       1'b0},
    '{MODE_QUERY,  20'h00000, 20'h00000, 1'b1, 21'd0,       1'b0},
    '{MODE_QUERY,  20'hFFFFF, 20'hFFFFF, 1'b1, 21'd2097150, 1'b0},
    '{MODE_QUERY,  20'hFFFFF, 20'h00000, 1'b1, 21'd1048575, 1'b0},
    '{MODE_QUERY,  20'h00000, 20'hFFFFF, 1'b1, 21'd1048575, 1'b0},
    '{MODE_INSERT, 20'hFFFFF, 20'hFFFFF, 1'b0, 21'd0,       1'b0},
    '{MODE_QUERY,  20'hFFFFF, 20'hFFFFF, 1'b1, 21'd0,       1'b0},
    '{MODE_QUERY,  20'h80000, 20'h80000, 1'b1, 21'd1048574, 1'b0},
    '{MODE_INSERT, 20'hFFFFF, 20'h00000, 1'b0, 21'd0,       1'b0},
    '{MODE_INSERT, 20'h00000, 20'hFFFFF, 1'b0, 21'd0,       1'b0},
    '{MODE_QUERY,  20'hAAAAA, 20'h55555, 1'b0, 21'd0,       1'b0},
    '{MODE_INSERT, 20'h00000, 20'h00000, 1'b0, 21'd0,       1'b0},
    '{MODE_INSERT, 20'h00000, 20'h00000, 1'b0, 21'd0,       1'b0},
    '{MODE_QUERY,  20'h00001, 20'h00001, 1'b1, 21'd2,       1'b0},
    '{MODE_INSERT, 20'h55555, 20'hAAAAA, 1'b0, 21'd0,       1'b0},
    '{MODE_QUERY,  20'h55555, 20'hAAAAA, 1'b1, 21'd0,       1'b0},
    '{MODE_QUERY,  20'h12345, 20'h6789A, 1'b0, 21'd0,       1'b0},
    '{MODE_QUERY,  20'hFFFFE, 20'h00001, 1'b1, 21'd2,       1'b0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;

  // local copy of the point store
  logic [COORD_W-1:0] stored_x [CAP];
  logic [COORD_W-1:0] stored_y [CAP];
  int                 stored_count = 0;

  nearest_result_t pending_results [$];
  int              fail_count = 0;
  bit              quiet_tail = 1'b0;

  manhattan_nearest_point_search_top #(
    .CAPACITY(CAP)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // brute-force minimum of |dx|+|dy| over the stored points
  function automatic nearest_result_t nearest_distance(logic [COORD_W-1:0] qx,
                                                       logic [COORD_W-1:0] qy);
    nearest_result_t   res;
    logic [DIST_W-1:0] d;
    logic [COORD_W-1:0] dx, dy;
    res.distance = DIST_INIT;
    res.empty    = 1'b0;
    if (stored_count == 0) begin
      res.distance = '0;
      res.empty    = 1'b1;
      return res;
    end
    for (int i = 0; i < stored_count; i++) begin
      dx = (stored_x[i] > qx) ? stored_x[i] - qx : qx - stored_x[i];
      dy = (stored_y[i] > qy) ? stored_y[i] - qy : qy - stored_y[i];
      d  = {1'b0, dx} + {1'b0, dy};
      if (d < res.distance) res.distance = d;
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > int'(COORD_MAX)) return COORD_MAX;
    return v[COORD_W-1:0];
  endfunction

  // corners, a dense cluster, or anywhere
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return COORD_MAX;
      2, 3, 4: return clamp_coord(32'h40000 + $urandom_range(0, 4095));
      default: return COORD_W'($urandom_range(0, int'(COORD_MAX)));
    endcase
  endfunction

  // drive one request and hold it until accepted; then update the model
  task automatic send_request(logic mode, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic typed, nearest_result_t typed_res);
    nearest_result_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
    if (mode == MODE_INSERT) begin
      if (stored_count < CAP) begin
        stored_x[stored_count] = x;
        stored_y[stored_count] = y;
        stored_count++;
      end
    end else begin
      res = nearest_distance(x, y);
      pending_results.push_back(typed ? typed_res : res);
    end
  endtask

  task automatic sender_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 15)) @(posedge clk);
  endtask

  // hold the sender until every query in flight has returned
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    nearest_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: distance=%0d empty=%0d",
                   out_tdata[DIST_W-1:0], out_tuser[0]);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata[DIST_W-1:0] !== exp_res.distance ||
            out_tuser[0] !== exp_res.empty) begin
          fail_count++;
          if (fail_count <= 10)
            $display({"result differs: expected distance=%0d empty=%0d,",
                      " got distance=%0d empty=%0d"},
                     exp_res.distance, exp_res.empty, out_tdata[DIST_W-1:0],
                     out_tuser[0]);
        end
      end
    end
  end

  // receiver backpressure in bursts, none in the tail
  initial begin
    wait (rst_n);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
  end

  // stimulus
  initial begin
    nearest_result_t    typed_res;
    logic               mode;
    logic [COORD_W-1:0] x, y;
    int                 idx;
    int                 accepted;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed_res.distance = directed_rows[i].distance;
      typed_res.empty    = directed_rows[i].empty;
      send_request(directed_rows[i].mode, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].typed, typed_res);
    end
    drain_results();

    typed_res = '0;
    accepted  = 0;
    while (accepted < RANDOM_COUNT) begin
      quiet_tail = (accepted >= RANDOM_COUNT - QUIET_TAIL);
      if (accepted == RANDOM_COUNT / 2) drain_results();
      if (!quiet_tail && $urandom_range(0, 4) == 0) sender_gap();

      // mostly inserts while filling, mostly queries once full
      if (stored_count < CAP) mode = ($urandom_range(0, 99) < 60) ? MODE_INSERT : MODE_QUERY;
      else                    mode = ($urandom_range(0, 99) < 25) ? MODE_INSERT : MODE_QUERY;

      x = rand_coord();
      y = rand_coord();
      if (stored_count > 0) begin
        idx = $urandom_range(0, stored_count - 1);
        case ($urandom_range(0, 9))
          // exact copy of a stored point
          0, 1: begin
            x = stored_x[idx];
            y = stored_y[idx];
          end
          // close to a stored point
          2, 3, 4: begin
            x = clamp_coord(int'(stored_x[idx]) + int'($urandom_range(0, 128)) - 64);
            y = clamp_coord(int'(stored_y[idx]) + int'($urandom_range(0, 128)) - 64);
          end
          default: ;
        endcase
      end

      // dropped inserts on a full store do not count
      if (!(mode == MODE_INSERT && stored_count >= CAP)) accepted++;
      send_request(mode, x, y, 1'b0, typed_res);
    end
    quiet_tail = 1'b1;
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAP + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("manhattan_nearest_point_search_top: match");
    end else begin
      $display("manhattan_nearest_point_search_top: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("manhattan_nearest_point_search_top: mismatch");
    $finish;
  end

endmodule
